[rtl/core/text_to_unsigned_parser_unit_macros.svh]
// Assertion macros for the text-to-unsigned parser.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef TEXT_TO_UNSIGNED_PARSER_UNIT_MACROS_SVH
`define TEXT_TO_UNSIGNED_PARSER_UNIT_MACROS_SVH

// Property that holds in the same cycle.
`define TTUP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define TTUP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ttup_pkg.sv]
// Package for the text-to-unsigned parser: types, constants, char decode.
// No dependencies.
package ttup_pkg;

  localparam int unsigned OffsetBits = 16;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned BaseW      = 6;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned EndOffW    = 16;
  localparam int unsigned RegIdxW    = ApbAddrW - 2;

  localparam logic [RegIdxW-1:0] RegRequestedBase = '0;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChLowO  = 8'h6F;

  localparam logic [BaseW-1:0] BaseDefault = 6'd10;
  localparam logic [BaseW-1:0] BaseHex     = 6'd16;
  localparam logic [BaseW-1:0] BaseOct     = 6'd8;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StEmpty    = 2'd1,
    StBadChar  = 2'd2,
    StBadDigit = 2'd3
  } status_e;

  typedef struct packed {
    logic             valid;
    logic [BaseW-1:0] value;
  } digit_t;

  typedef struct packed {
    logic [ValueW-1:0]  value;
    status_e            status;
    logic [EndOffW-1:0] end_offset;
  } result_t;

  // Maps 0-9, a-z, A-Z to 0..35.
  function automatic digit_t decode_char(logic [7:0] c);
    digit_t d;
    logic [7:0] t;
    d = '0;
    t = '0;
    if (c >= ChZero && c <= ChNine) begin
      t = c - ChZero;
      d.valid = 1'b1;
    end else if (c >= ChLowA && c <= ChLowZ) begin
      t = c - ChLowA + 8'd10;
      d.valid = 1'b1;
    end else if (c >= ChUpA && c <= ChUpZ) begin
      t = c - ChUpA + 8'd10;
      d.valid = 1'b1;
    end
    d.value = t[BaseW-1:0];
    return d;
  endfunction

endpackage

[rtl/core/ttup_if.sv]
// Stream interfaces of the parser: character input and result output.
// Depends on ttup_pkg.
interface ttup_in_if;
  import ttup_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface ttup_out_if;
  import ttup_pkg::*;
  logic               valid;
  logic               ready;
  logic [ValueW-1:0]  value;
  logic [1:0]         status;
  logic [EndOffW-1:0] end_offset;

  modport source (output valid, output value, output status, output end_offset, input ready);
  modport sink (input valid, input value, input status, input end_offset, output ready);
endinterface

[rtl/core/ttup_cfg_regs.sv]
// APB register block of the parser: holds requested_base.
// Depends on ttup_pkg.
module ttup_cfg_regs import ttup_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output logic [BaseW-1:0]    req_base_o
);

  logic [BaseW-1:0]   req_base_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;

  assign reg_idx = paddr[ApbAddrW-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && (reg_idx == RegRequestedBase);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_base_q <= '0;
    end else if (wr_en) begin
      req_base_q <= pwdata[BaseW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegRequestedBase: prdata = {{(ApbDataW-BaseW){1'b0}}, req_base_q};
      default:          prdata = '0;
    endcase
  end

  assign req_base_o = req_base_q;

endmodule

[rtl/core/ttup_parse_core.sv]
// Input register and per-string parse state of the parser.
// Depends on ttup_pkg and ttup_in_if.
module ttup_parse_core import ttup_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  ttup_in_if.sink          chr_i,
  input  logic [BaseW-1:0] req_base_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output result_t          res_o
);

  logic                  in_valid_q;
  logic [7:0]            ch_q;
  logic [ValueW-1:0]     value_q, value_d;
  logic [BaseW-1:0]      base_q, base_d;
  logic [OffsetBits-1:0] count_q, count_d, count_inc;
  logic                  lz_q, lz_d;
  logic                  stop_q, stop_d;
  status_e               err_q, err_d;
  logic [OffsetBits-1:0] stop_off_q, stop_off_d;

  logic                  is_nul, step, first;
  logic [BaseW-1:0]      eff_base;
  digit_t                dig;
  logic [ValueW-1:0]     mac;

  assign is_nul = (ch_q == ChNul);
  // A NUL needs room in the result register; other chars always move on.
  assign step   = in_valid_q && (!is_nul || res_ready_i);
  assign chr_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (chr_i.valid && chr_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chr_i.valid && chr_i.ready) begin
      ch_q <= chr_i.ch;
    end
  end

  assign first     = (count_q == '0);
  assign eff_base  = first ? ((req_base_i != '0) ? req_base_i : BaseDefault) : base_q;
  assign dig       = decode_char(ch_q);
  assign count_inc = (count_q == '1) ? count_q : count_q + OffsetBits'(1);
  assign mac       = value_q * {{(ValueW-BaseW){1'b0}}, eff_base}
                   + {{(ValueW-BaseW){1'b0}}, dig.value};

  always_comb begin
    value_d    = value_q;
    base_d     = base_q;
    count_d    = count_q;
    lz_d       = lz_q;
    stop_d     = stop_q;
    err_d      = err_q;
    stop_off_d = stop_off_q;
    res_o.value      = value_q;
    res_o.status     = StOk;
    res_o.end_offset = EndOffW'(count_q);
    res_valid_o      = 1'b0;
    if (step) begin
      if (is_nul) begin
        res_valid_o = 1'b1;
        if (first && !stop_q) begin
          res_o.status     = StEmpty;
          res_o.end_offset = '0;
        end else if (stop_q) begin
          res_o.status     = err_q;
          res_o.end_offset = EndOffW'(stop_off_q);
        end
        value_d    = '0;
        base_d     = '0;
        count_d    = '0;
        lz_d       = 1'b0;
        stop_d     = 1'b0;
        err_d      = StOk;
        stop_off_d = '0;
      end else if (!stop_q) begin
        base_d = eff_base;
        if (first && ch_q == ChZero) begin
          lz_d    = 1'b1;
          count_d = count_inc;
        end else if (lz_q && count_q == OffsetBits'(1) && ch_q == ChLowX) begin
          base_d  = BaseHex;
          count_d = count_inc;
        end else if (lz_q && count_q == OffsetBits'(1) && ch_q == ChLowO) begin
          base_d  = BaseOct;
          count_d = count_inc;
        end else if (!dig.valid) begin
          stop_d     = 1'b1;
          err_d      = StBadChar;
          stop_off_d = count_q;
        end else if (dig.value >= eff_base) begin
          stop_d     = 1'b1;
          err_d      = StBadDigit;
          stop_off_d = count_q;
        end else begin
          value_d = mac;
          count_d = count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q    <= '0;
      base_q     <= '0;
      count_q    <= '0;
      lz_q       <= 1'b0;
      stop_q     <= 1'b0;
      err_q      <= StOk;
      stop_off_q <= '0;
    end else begin
      value_q    <= value_d;
      base_q     <= base_d;
      count_q    <= count_d;
      lz_q       <= lz_d;
      stop_q     <= stop_d;
      err_q      <= err_d;
      stop_off_q <= stop_off_d;
    end
  end

endmodule

[rtl/core/ttup_result_reg.sv]
// Output register of the parser: holds one result item until taken.
// Depends on ttup_pkg and ttup_out_if.
module ttup_result_reg import ttup_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     res_valid_i,
  output logic     res_ready_o,
  input  result_t  res_i,
  ttup_out_if.source res_o
);

  logic    valid_q;
  result_t data_q;

  assign res_ready_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_valid_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid      = valid_q;
  assign res_o.value      = data_q.value;
  assign res_o.status     = data_q.status;
  assign res_o.end_offset = data_q.end_offset;

endmodule

[rtl/core/text_to_unsigned_parser_unit.sv]
// Top level of the text-to-unsigned parser: APB registers, parse core, result register.
// Depends on ttup_pkg, ttup_if, ttup_cfg_regs, ttup_parse_core, ttup_result_reg and the assertion macro header.

// Parses a NUL-terminated ASCII string, one character per item, into a 32-bit
// unsigned value (base from requested_base, 0 meaning decimal, or from a 0x/0o
// prefix). One character is taken every clock cycle unless the input stalls; the
// throughput is set by the single 32x6 multiply-add that closes the value
// feedback loop. A result item passes the input register, then the result
// register, after its NUL is accepted, and is held there until taken. Input stalls
// only while a NUL waits behind an untaken result.
`include "text_to_unsigned_parser_unit_macros.svh"

module text_to_unsigned_parser_unit import ttup_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  ttup_in_if.sink             chr_i,
  ttup_out_if.source          res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [BaseW-1:0] req_base;
  logic             res_push;
  logic             res_ready;
  result_t          res_data;
  logic             res_empty;

  ttup_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .req_base_o (req_base)
  );

  ttup_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .chr_i       (chr_i),
    .req_base_i  (req_base),
    .res_valid_o (res_push),
    .res_ready_i (res_ready),
    .res_o       (res_data)
  );

  ttup_result_reg u_res (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_push),
    .res_ready_o (res_ready),
    .res_i       (res_data),
    .res_o       (res_o)
  );

  assign res_empty = res_o.valid && (res_o.status == StEmpty);

  // Input only backs up behind a result that is held and not taken.
  `TTUP_ASSERT(a_stall_cause, !chr_i.ready |-> (res_o.valid && !res_o.ready), "input stall")
  // A pushed result shows up on the output in the next cycle.
  `TTUP_ASSERT_NEXT(a_push_visible, res_push, res_o.valid, "pushed result not visible")
  // Empty strings report zero value at offset zero.
  `TTUP_ASSERT(a_empty_zero, res_empty |-> ({res_o.value, res_o.end_offset} == '0), "empty not 0")

endmodule
